// File: rtl/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared operation codes for the max segment tree engine.
// ----------------------------------------------------------------------------
package mst_pkg;
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_MAX   = 2'd1;
  localparam logic [1:0] OP_GE    = 2'd2;
  localparam logic [1:0] OP_GT    = 2'd3;
endpackage

// File: rtl/mst_ram.sv
// ----------------------------------------------------------------------------
// mst_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mst_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/max_segment_tree_engine.sv
// ----------------------------------------------------------------------------
// max_segment_tree_engine
// Max segment tree over LEAVES signed elements with range max and
// leftmost-index threshold search.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid_i/in_stall_o with operation, position,
// range and value; one result leaves per request on out_valid_o/out_stall_i.
// One request is in work at a time. All node accesses go through a single
// RAM with one registered read port. A write stores the leaf, then for each
// level above it reads the left child, reads the right child and writes the
// parent. A range max reads and folds each node visited, and moves up a
// level where no node is visited. A search tests elements one by one from
// range_start; a bad range goes straight to the result.
// The result is held in an output register; the next request is taken once
// the result has left.
// After reset the block sweeps all 2*LEAVES RAM entries to zero, one entry a
// cycle, with in_stall_o high; cfg writes are taken at any time.
// A stalled result holds until taken.
// ----------------------------------------------------------------------------
module max_segment_tree_engine import mst_pkg::*; #(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  position_i,
  input  logic [9:0]  range_start_i,
  input  logic [9:0]  range_end_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] max_value_o,
  output logic        found_o,
  output logic [9:0]  found_index_o,
  output logic        range_error_o
);
  localparam int AW = $clog2(2 * LEAVES);
  localparam int LW = $clog2(LEAVES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WRD0 = 4'd2;  // issue read left child
  localparam logic [3:0] S_WRD1 = 4'd3;  // capture left, issue right
  localparam logic [3:0] S_WUPD = 4'd4;  // capture right, write parent
  localparam logic [3:0] S_QCHK = 4'd5;  // decide next node of range max
  localparam logic [3:0] S_QDAT = 4'd6;  // fold read node
  localparam logic [3:0] S_SRD  = 4'd7;  // issue leaf read
  localparam logic [3:0] S_SCHK = 4'd8;  // test leaf
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [AW:0]   clr_q, clr_d;
  logic [10:0]   size_q;
  logic [1:0]    op_q, op_d;
  logic [LW-1:0] end_q, end_d;
  logic [63:0]   val_q, val_d;
  logic [AW-1:0] node_q, node_d;   // write: current parent; search: leaf addr
  logic [AW:0]   l_q, l_d, r_q, r_d;
  logic          rside_q, rside_d; // range max: pending read is from r side
  logic          first_q, first_d;
  logic [63:0]   left_q, left_d, best_q, best_d;
  logic [63:0]   mx_q, mx_d;
  logic          fnd_q, fnd_d, err_q, err_d;
  logic [LW-1:0] fidx_q, fidx_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  mst_ram #(.Width(64), .Depth(2 * LEAVES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic sgt(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) > $signed(b);
  endfunction

  logic [11:0]   n_eff;
  logic [63:0]   vnar;
  logic [AW:0]   lnx, rnx;
  logic [LW-1:0] sidx;
  assign n_eff = (int'(size_q) > LEAVES) ? 12'(LEAVES) : {1'b0, size_q};
  assign vnar = 64'($signed(value_i[VALUE_BITS-1:0]));
  // element index of the leaf under scan
  assign sidx = LW'(node_q - AW'(LEAVES));

  always_comb begin
    state_d = state_q; clr_d = clr_q; op_d = op_q; end_d = end_q;
    val_d = val_q; node_d = node_q; l_d = l_q; r_d = r_q; rside_d = rside_q;
    first_d = first_q; left_d = left_q; best_d = best_q; mx_d = mx_q;
    fnd_d = fnd_q; err_d = err_q; fidx_d = fidx_q;
    we = 1'b0; waddr = node_q; wdata = val_q; raddr = node_q;
    lnx = l_q; rnx = r_q;
    case (state_q)
      S_CLR: begin
        we = 1'b1; waddr = clr_q[AW-1:0]; wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(2 * LEAVES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i; val_d = vnar; end_d = LW'(range_end_i);
          mx_d = '0; fnd_d = 1'b0; fidx_d = '0; err_d = 1'b0;
          if (operation_i == OP_WRITE) begin
            if (12'(position_i) >= n_eff) begin
              err_d = 1'b1; state_d = S_OUT;
            end else begin
              we = 1'b1;
              waddr = AW'(LEAVES) + AW'(position_i);
              wdata = vnar;
              node_d = (AW'(LEAVES) + AW'(position_i)) >> 1;
              state_d = S_WRD0;
            end
          end else if (range_start_i > range_end_i || 12'(range_end_i) >= n_eff) begin
            err_d = 1'b1; state_d = S_OUT;
          end else if (operation_i == OP_MAX) begin
            l_d = (AW+1)'(LEAVES) + (AW+1)'(range_start_i);
            r_d = (AW+1)'(LEAVES) + (AW+1)'(range_end_i) + 1'b1;
            first_d = 1'b1;
            state_d = S_QCHK;
          end else begin
            node_d = AW'(LEAVES) + AW'(range_start_i);
            state_d = S_SRD;
          end
        end
      end
      S_WRD0: begin
        raddr = {node_q[AW-2:0], 1'b0};
        state_d = S_WRD1;
      end
      S_WRD1: begin
        left_d = rdata;
        raddr = {node_q[AW-2:0], 1'b1};
        state_d = S_WUPD;
      end
      S_WUPD: begin
        we = 1'b1; waddr = node_q;
        wdata = sgt(rdata, left_q) ? rdata : left_q;
        node_d = node_q >> 1;
        state_d = (node_q == AW'(1)) ? S_OUT : S_WRD0;
      end
      S_QCHK: begin
        if (l_q >= r_q) begin
          mx_d = best_q; state_d = S_OUT;
        end else if (l_q[0]) begin
          raddr = l_q[AW-1:0]; rside_d = 1'b0; state_d = S_QDAT;
        end else if (r_q[0]) begin
          raddr = AW'(r_q - 1'b1); rside_d = 1'b1; state_d = S_QDAT;
        end else begin
          l_d = l_q >> 1; r_d = r_q >> 1;
        end
      end
      S_QDAT: begin
        best_d = (first_q || sgt(rdata, best_q)) ? rdata : best_q;
        first_d = 1'b0;
        if (!rside_q) begin
          lnx = l_q + 1'b1;
        end else begin
          rnx = r_q - 1'b1;
        end
        // after the left step the right step of this level may still be due
        if (!rside_q && r_q[0] && lnx < r_q) begin
          l_d = lnx; state_d = S_QCHK;
        end else begin
          l_d = lnx >> 1; r_d = rnx >> 1; state_d = S_QCHK;
        end
      end
      S_SRD: begin
        raddr = node_q; state_d = S_SCHK;
      end
      S_SCHK: begin
        if ((op_q == OP_GE) ? !sgt(val_q, rdata) : sgt(rdata, val_q)) begin
          fnd_d = 1'b1; fidx_d = sidx; state_d = S_OUT;
        end else if (sidx == end_q) begin
          state_d = S_OUT;
        end else begin
          node_d = node_q + 1'b1; state_d = S_SRD;
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      size_q  <= 11'd1024;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; end_q <= end_d; val_q <= val_d; node_q <= node_d;
    l_q <= l_d; r_q <= r_d; rside_q <= rside_d; first_q <= first_d;
    left_q <= left_d; best_q <= best_d; mx_q <= mx_d;
    fnd_q <= fnd_d; err_q <= err_d; fidx_q <= fidx_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign max_value_o   = mx_q;
  assign found_o       = fnd_q;
  assign found_index_o = 10'(fidx_q);
  assign range_error_o = err_q;

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o)) else $error("accept while result pending");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (!found_o && max_value_o == '0))
    else $error("error result carries data");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
`endif
endmodule

// File: tb/sv/max_segment_tree_engine_test.sv
// ----------------------------------------------------------------------------
// max_segment_tree_engine_test
// Drives random and directed writes, range max and threshold searches into
// the segment tree engine and checks every result against a flat array model.
// ----------------------------------------------------------------------------
module max_segment_tree_engine_test;
  import mst_pkg::*;

  localparam int LEAVES = 1024;
  localparam int RANDOM_REQUESTS = 1950;
  localparam longint CYCLE_LIMIT = 64'd20000000;

  typedef struct packed {
    logic [63:0] max_value;
    logic        found;
    logic [9:0]  found_index;
    logic        range_error;
  } tree_result_t;

  class tree_scoreboard;
    logic signed [63:0] elements[LEAVES];
    int unsigned size_reg;
    tree_result_t pending_results[$];
    int errors;

    function new();
      foreach (elements[i]) elements[i] = '0;
      size_reg = 1024;
      errors = 0;
    endfunction

    function void note_request(logic [1:0] op, logic [9:0] pos, logic [9:0] rs,
                               logic [9:0] re, logic signed [63:0] val);
      tree_result_t r;
      int unsigned n;
      logic signed [63:0] best;
      r = '0;
      n = (size_reg > LEAVES) ? LEAVES : size_reg;
      if (op == OP_WRITE) begin
        if (pos >= n) r.range_error = 1'b1;
        else elements[pos] = val;
      end else if (rs > re || re >= n) begin
        r.range_error = 1'b1;
      end else if (op == OP_MAX) begin
        best = elements[rs];
        for (int i = rs; i <= re; i++) if (elements[i] > best) best = elements[i];
        r.max_value = best;
      end else begin
        for (int i = rs; i <= re; i++) begin
          if ((op == OP_GE) ? (elements[i] >= val) : (elements[i] > val)) begin
            r.found = 1'b1;
            r.found_index = i[9:0];
            break;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(tree_result_t got);
      tree_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no pending request");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.max_value !== e.max_value) begin
        $error("max_value expected %0d actual %0d", $signed(e.max_value),
               $signed(got.max_value));
        errors++;
      end
      if (got.found !== e.found) begin
        $error("found expected %0d actual %0d", e.found, got.found);
        errors++;
      end
      if (got.found_index !== e.found_index) begin
        $error("found_index expected %0d actual %0d", e.found_index, got.found_index);
        errors++;
      end
      if (got.range_error !== e.range_error) begin
        $error("range_error expected %0d actual %0d", e.range_error, got.range_error);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [9:0]  position_i = '0;
  logic [9:0]  range_start_i = '0;
  logic [9:0]  range_end_i = '0;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] max_value_o;
  logic        found_o;
  logic [9:0]  found_index_o;
  logic        range_error_o;

  tree_scoreboard sb = new();
  longint cycle_count = 0;
  int unsigned cur_size = 1024;

  max_segment_tree_engine u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .operation_i, .position_i, .range_start_i, .range_end_i, .value_i,
    .out_valid_o, .out_stall_i, .max_value_o, .found_o, .found_index_o,
    .range_error_o
  );

  always #2 clk_i = ~clk_i;

  // Note accepted requests and check results at the rising edge.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_request(operation_i, position_i, range_start_i, range_end_i, value_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({max_value_o, found_o, found_index_o, range_error_o});
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Stall the result side at random; hold some stretches with no stall.
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (cycle_count % 6000 < 1500) out_stall_i <= 1'b0;
      else begin
        g = gap_len();
        out_stall_i <= (g != 0);
        repeat (g) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [9:0] pos, logic [9:0] rs,
                              logic [9:0] re, logic [63:0] val, bit no_gap);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    position_i <= pos;
    range_start_i <= rs;
    range_end_i <= re;
    value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic set_size(int unsigned sz);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= sz[10:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.size_reg = sz;
    cur_size = sz;
  endtask

  function automatic logic [63:0] rand_value();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return 64'h8000_0000_0000_0000;
    if (p == 1) return 64'h7fff_ffff_ffff_ffff;
    if (p < 5) return {{32{1'b0}}, 32'($urandom_range(0, 40))} - 64'd20;
    return {$urandom(), $urandom()};
  endfunction

  // Keep ranges short so searches stay cheap, with a few long ones.
  task automatic random_request();
    logic [1:0] op;
    logic [9:0] rs, re, pos;
    int unsigned span, lim;
    op = 2'($urandom_range(0, 3));
    lim = (cur_size == 0) ? 1 : ((cur_size > LEAVES) ? LEAVES : cur_size);
    pos = 10'($urandom_range(0, lim - 1));
    rs = 10'($urandom_range(0, lim - 1));
    span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
    re = (rs + span >= lim) ? 10'(lim - 1) : 10'(rs + span);
    if ($urandom_range(0, 14) == 0) begin
      pos = 10'($urandom());
      rs = 10'($urandom());
      re = 10'($urandom());
    end
    send_request(op, pos, rs, re, rand_value(), 1'b0);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: extremes, every operation, bad ranges and sizes.
    send_request(OP_MAX, 0, 0, 1023, 0, 0);
    send_request(OP_WRITE, 0, 0, 0, 64'h8000_0000_0000_0000, 0);
    send_request(OP_WRITE, 1023, 0, 0, 64'h7fff_ffff_ffff_ffff, 0);
    send_request(OP_WRITE, 512, 0, 0, 64'hffff_ffff_ffff_ffff, 0);
    send_request(OP_MAX, 0, 0, 1023, 0, 0);
    send_request(OP_MAX, 0, 0, 0, 0, 0);
    send_request(OP_MAX, 0, 0, 511, 0, 0);
    send_request(OP_GE, 0, 0, 1023, 64'h7fff_ffff_ffff_ffff, 0);
    send_request(OP_GT, 0, 0, 1023, 64'h7fff_ffff_ffff_ffff, 0);
    send_request(OP_GE, 0, 0, 1023, 64'h8000_0000_0000_0000, 0);
    send_request(OP_GT, 0, 0, 1023, 64'hffff_ffff_ffff_ffff, 0);
    send_request(OP_MAX, 0, 5, 4, 0, 0);
    send_request(OP_GE, 0, 1023, 0, 0, 0);
    set_size(16);
    send_request(OP_WRITE, 16, 0, 0, 5, 0);
    send_request(OP_MAX, 0, 0, 16, 0, 0);
    send_request(OP_MAX, 0, 15, 15, 0, 0);
    set_size(0);
    send_request(OP_WRITE, 0, 0, 0, 1, 0);
    send_request(OP_MAX, 0, 0, 0, 0, 0);
    set_size(11'h7ff);
    send_request(OP_MAX, 0, 0, 1023, 0, 0);
    set_size(1);
    send_request(OP_WRITE, 1, 0, 0, 1, 0);
    send_request(OP_GT, 0, 0, 0, 64'h8000_0000_0000_0000, 0);
    // Random phases over several sizes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_size(1024);
        1: set_size(8);
        2: set_size($urandom_range(2, 1023));
        3: set_size(1);
        4: set_size(1024);
        default: set_size($urandom_range(0, 2047));
      endcase
      for (int k = 0; k < RANDOM_REQUESTS / 6; k++) begin
        if (k == 40) drain_results();
        random_request();
      end
    end
    drain_results();
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: filelist.f
rtl/mst_pkg.sv
rtl/mst_ram.sv
rtl/max_segment_tree_engine.sv
tb/sv/max_segment_tree_engine_test.sv
